/* src/fr_pkg.sv */
package fr_pkg;

   localparam int SQ_STEPS  = 29;
   localparam int DV1_STEPS = 28;
   localparam int DV2_STEPS = 31;

   localparam logic        CSR_IDX_INDEX = 1'b0;
   localparam logic [14:0] INDEX_RESET   = 15'd6144;
   localparam logic [14:0] ETA_ONE       = 15'd4096;
   localparam logic [15:0] ONE_Q15       = 16'd32768;

   // stage positions along the valid line
   localparam int P_PROD  = 0;
   localparam int P_CI    = P_PROD + 1;
   localparam int P_SQ1   = P_CI + 1;
   localparam int P_MUL1  = P_SQ1 + SQ_STEPS + 1;
   localparam int P_DV1   = P_MUL1 + 1;
   localparam int P_SQ2   = P_DV1 + DV1_STEPS + 1;
   localparam int P_MUL2  = P_SQ2 + SQ_STEPS + 1;
   localparam int P_DV2   = P_MUL2 + 1;
   localparam int P_SQR   = P_DV2 + DV2_STEPS + 1;
   localparam int P_OUT   = P_SQR + 1;
   localparam int N_STAGES = P_OUT + 1;

   typedef struct packed {
      logic        tir;
      logic [28:0] ci;
      logic [14:0] eta_i;
      logic [14:0] eta_t;
   } ctx_type;

   typedef struct packed {
      logic [57:0] x;
      logic [31:0] r;
      logic [28:0] q;
   } sq_type;

   typedef struct packed {
      logic [15:0] r;
      logic [27:0] d;
      logic [27:0] q;
   } dv1_type;

   typedef struct packed {
      logic [31:0] r;
      logic [30:0] d;
      logic [30:0] q;
   } dv2_type;

   typedef struct packed {
      logic        tir;
      logic [30:0] a_s;
      logic [30:0] b_s;
      logic [30:0] a_p;
      logic [30:0] b_p;
   } mul_type;

   typedef struct packed {
      logic        tir;
      logic        dz_s;
      logic        dz_p;
      logic [31:0] den_s;
      logic [31:0] den_p;
   } rt_type;

   // one result bit of a floor square root
   function automatic sq_type sq_step(sq_type s);
      logic [33:0] rs;
      logic [33:0] t;
      sq_type      o;
      rs  = {s.r, s.x[57:56]};
      t   = {3'b000, s.q, 2'b01};
      o.x = {s.x[55:0], 2'b00};
      if (rs >= t) begin
         o.r = 32'(rs - t);
         o.q = {s.q[27:0], 1'b1};
      end else begin
         o.r = rs[31:0];
         o.q = {s.q[27:0], 1'b0};
      end
      return o;
   endfunction

   function automatic dv1_type dv1_step(dv1_type s, logic [14:0] den);
      logic [16:0] rs;
      logic [16:0] dd;
      dv1_type     o;
      rs  = {s.r, s.d[27]};
      dd  = {2'b00, den};
      o.d = {s.d[26:0], 1'b0};
      if (rs >= dd) begin
         o.r = 16'(rs - dd);
         o.q = {s.q[26:0], 1'b1};
      end else begin
         o.r = rs[15:0];
         o.q = {s.q[26:0], 1'b0};
      end
      return o;
   endfunction

   function automatic dv2_type dv2_step(dv2_type s, logic [31:0] den);
      logic [32:0] rs;
      logic [32:0] dd;
      dv2_type     o;
      rs  = {s.r, s.d[30]};
      dd  = {1'b0, den};
      o.d = {s.d[29:0], 1'b0};
      if (rs >= dd) begin
         o.r = 32'(rs - dd);
         o.q = {s.q[29:0], 1'b1};
      end else begin
         o.r = rs[31:0];
         o.q = {s.q[29:0], 1'b0};
      end
      return o;
   endfunction

endpackage

/* src/fr_req_if.sv */
interface fr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;

   modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                   input ready);
   modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                 output ready);
endinterface

/* src/fr_rsp_if.sv */
interface fr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] reflectance;
   logic        total_internal;

   modport source (output valid, reflectance, total_internal, input ready);
   modport sink (input valid, reflectance, total_internal, output ready);
endinterface

/* src/fresnel_reflectance.sv */
// Unpolarized Fresnel reflectance, fully pipelined: one ray/normal pair is
// taken every cycle unless the output stalls, and its result passes through
// 127 register stages. The depth comes from two square roots and two
// restoring dividers (28 and 31 steps) that each settle one result bit per
// stage; the whole pipe holds when the result register is full and not taken.
// refractive_index is written over the APB port at byte address 0; the user
// must do so only while no item is in flight, which the block does not enforce.
module fresnel_reflectance (
   input  logic        clock,
   input  logic        reset,
   fr_req_if.sink      req_ch,
   fr_rsp_if.source    rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [14:0] index_ff;
   logic        en;
   logic [fr_pkg::N_STAGES-1:0] vld_ff;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == fr_pkg::CSR_IDX_INDEX) ? {17'd0, index_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= fr_pkg::INDEX_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == fr_pkg::CSR_IDX_INDEX) begin
         index_ff <= csr_pwdata[14:0];
      end
   end

   // advance everything unless the result register holds an untaken transfer
   assign en           = !vld_ff[fr_pkg::P_OUT] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid = vld_ff[fr_pkg::P_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[fr_pkg::N_STAGES-2:0], req_ch.valid};
      end
   end

   // products of the dot product
   logic signed [31:0] px_ff, py_ff, pz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= req_ch.dir_x * req_ch.norm_x;
         py_ff <= req_ch.dir_y * req_ch.norm_y;
         pz_ff <= req_ch.dir_z * req_ch.norm_z;
      end
   end

   // sum, clamp, pick indices
   logic signed [33:0] dot;
   fr_pkg::ctx_type    ci_in, ci_ff;
   always_comb begin
      dot = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);
      ci_in.tir = 1'b0;
      if (dot > 34'sd268435456) begin
         ci_in.ci = 29'd268435456;
      end else if (dot < -34'sd268435456) begin
         ci_in.ci = 29'd268435456;
      end else if (dot < 34'sd0) begin
         ci_in.ci = 29'(-dot);
      end else begin
         ci_in.ci = dot[28:0];
      end
      if (dot > 34'sd0) begin
         ci_in.eta_i = index_ff;
         ci_in.eta_t = fr_pkg::ETA_ONE;
      end else begin
         ci_in.eta_i = fr_pkg::ETA_ONE;
         ci_in.eta_t = index_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) ci_ff <= ci_in;
   end

   // sin_i = sqrt(1 - cos_i^2)
   fr_pkg::sq_type  sq1_ff [fr_pkg::SQ_STEPS+1];
   fr_pkg::ctx_type c1_ff  [fr_pkg::SQ_STEPS+1];
   logic [57:0] ci_sq;
   assign ci_sq = 58'(ci_ff.ci) * 58'(ci_ff.ci);
   always_ff @(posedge clock) begin
      if (en) begin
         sq1_ff[0].x <= (58'd1 << 56) - ci_sq;
         sq1_ff[0].r <= '0;
         sq1_ff[0].q <= '0;
         c1_ff[0]    <= ci_ff;
      end
   end
   for (genvar k = 1; k <= fr_pkg::SQ_STEPS; k++) begin : g_sq1
      always_ff @(posedge clock) begin
         if (en) begin
            sq1_ff[k] <= fr_pkg::sq_step(sq1_ff[k-1]);
            c1_ff[k]  <= c1_ff[k-1];
         end
      end
   end

   // eta_i * sin_i
   logic [43:0]     m1_ff;
   fr_pkg::ctx_type cm1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= 44'(c1_ff[fr_pkg::SQ_STEPS].eta_i)
                   * 44'(sq1_ff[fr_pkg::SQ_STEPS].q);
         cm1_ff.ci    <= c1_ff[fr_pkg::SQ_STEPS].ci;
         cm1_ff.eta_i <= c1_ff[fr_pkg::SQ_STEPS].eta_i;
         cm1_ff.eta_t <= c1_ff[fr_pkg::SQ_STEPS].eta_t;
         cm1_ff.tir   <= (c1_ff[fr_pkg::SQ_STEPS].eta_t == 15'd0);
      end
   end

   // sin_t = eta_i * sin_i / eta_t; quotient of 2^28 or more is total reflection
   fr_pkg::dv1_type dv1_ff [fr_pkg::DV1_STEPS+1];
   fr_pkg::ctx_type d1_ff  [fr_pkg::DV1_STEPS+1];
   always_ff @(posedge clock) begin
      if (en) begin
         dv1_ff[0].r <= m1_ff[43:28];
         dv1_ff[0].d <= m1_ff[27:0];
         dv1_ff[0].q <= '0;
         d1_ff[0].ci    <= cm1_ff.ci;
         d1_ff[0].eta_i <= cm1_ff.eta_i;
         d1_ff[0].eta_t <= cm1_ff.eta_t;
         d1_ff[0].tir   <= cm1_ff.tir || (m1_ff >= {1'b0, cm1_ff.eta_t, 28'd0});
      end
   end
   for (genvar k = 1; k <= fr_pkg::DV1_STEPS; k++) begin : g_dv1
      always_ff @(posedge clock) begin
         if (en) begin
            dv1_ff[k] <= fr_pkg::dv1_step(dv1_ff[k-1], d1_ff[k-1].eta_t);
            d1_ff[k]  <= d1_ff[k-1];
         end
      end
   end

   // cos_t = sqrt(1 - sin_t^2)
   fr_pkg::sq_type  sq2_ff [fr_pkg::SQ_STEPS+1];
   fr_pkg::ctx_type c2_ff  [fr_pkg::SQ_STEPS+1];
   logic [57:0] st_sq;
   assign st_sq = 58'(dv1_ff[fr_pkg::DV1_STEPS].q) * 58'(dv1_ff[fr_pkg::DV1_STEPS].q);
   always_ff @(posedge clock) begin
      if (en) begin
         sq2_ff[0].x <= (58'd1 << 56) - st_sq;
         sq2_ff[0].r <= '0;
         sq2_ff[0].q <= '0;
         c2_ff[0]    <= d1_ff[fr_pkg::DV1_STEPS];
      end
   end
   for (genvar k = 1; k <= fr_pkg::SQ_STEPS; k++) begin : g_sq2
      always_ff @(posedge clock) begin
         if (en) begin
            sq2_ff[k] <= fr_pkg::sq_step(sq2_ff[k-1]);
            c2_ff[k]  <= c2_ff[k-1];
         end
      end
   end

   // the four index products, truncated to Q.28
   fr_pkg::ctx_type cx;
   logic [28:0]     cos_t;
   logic [43:0]     ms, ns, mp, np;
   fr_pkg::mul_type m2_ff;
   always_comb begin
      cx    = c2_ff[fr_pkg::SQ_STEPS];
      cos_t = sq2_ff[fr_pkg::SQ_STEPS].q;
      ms    = 44'(cx.eta_t) * 44'(cx.ci);
      ns    = 44'(cx.eta_i) * 44'(cos_t);
      mp    = 44'(cx.eta_i) * 44'(cx.ci);
      np    = 44'(cx.eta_t) * 44'(cos_t);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m2_ff.tir <= cx.tir;
         m2_ff.a_s <= ms[42:12];
         m2_ff.b_s <= ns[42:12];
         m2_ff.a_p <= mp[42:12];
         m2_ff.b_p <= np[42:12];
      end
   end

   // |a - b| * 2^30 / (a + b) for Rs and Rp
   logic [30:0] num_s, num_p;
   logic [31:0] den_s, den_p;
   always_comb begin
      num_s = (m2_ff.a_s >= m2_ff.b_s) ? m2_ff.a_s - m2_ff.b_s : m2_ff.b_s - m2_ff.a_s;
      num_p = (m2_ff.a_p >= m2_ff.b_p) ? m2_ff.a_p - m2_ff.b_p : m2_ff.b_p - m2_ff.a_p;
      den_s = 32'(m2_ff.a_s) + 32'(m2_ff.b_s);
      den_p = 32'(m2_ff.a_p) + 32'(m2_ff.b_p);
   end

   fr_pkg::dv2_type ds_ff [fr_pkg::DV2_STEPS+1];
   fr_pkg::dv2_type dp_ff [fr_pkg::DV2_STEPS+1];
   fr_pkg::rt_type  rt_ff [fr_pkg::DV2_STEPS+1];
   always_ff @(posedge clock) begin
      if (en) begin
         ds_ff[0].r <= 32'(num_s[30:1]);
         ds_ff[0].d <= {num_s[0], 30'd0};
         ds_ff[0].q <= '0;
         dp_ff[0].r <= 32'(num_p[30:1]);
         dp_ff[0].d <= {num_p[0], 30'd0};
         dp_ff[0].q <= '0;
         rt_ff[0].tir   <= m2_ff.tir;
         rt_ff[0].dz_s  <= (den_s == 32'd0);
         rt_ff[0].dz_p  <= (den_p == 32'd0);
         rt_ff[0].den_s <= den_s;
         rt_ff[0].den_p <= den_p;
      end
   end
   for (genvar k = 1; k <= fr_pkg::DV2_STEPS; k++) begin : g_dv2
      always_ff @(posedge clock) begin
         if (en) begin
            ds_ff[k] <= fr_pkg::dv2_step(ds_ff[k-1], rt_ff[k-1].den_s);
            dp_ff[k] <= fr_pkg::dv2_step(dp_ff[k-1], rt_ff[k-1].den_p);
            rt_ff[k] <= rt_ff[k-1];
         end
      end
   end

   // squares of the two ratios
   fr_pkg::rt_type rl;
   logic [30:0]    rs_q, rp_q;
   logic [61:0]    sqs_ff, sqp_ff;
   logic           tir_sq_ff;
   always_comb begin
      rl   = rt_ff[fr_pkg::DV2_STEPS];
      rs_q = rl.dz_s ? 31'd1 << 30 : ds_ff[fr_pkg::DV2_STEPS].q;
      rp_q = rl.dz_p ? 31'd1 << 30 : dp_ff[fr_pkg::DV2_STEPS].q;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sqs_ff    <= 62'(rs_q) * 62'(rs_q);
         sqp_ff    <= 62'(rp_q) * 62'(rp_q);
         tir_sq_ff <= rl.tir;
      end
   end

   // halve, round half up to Q1.15, saturate
   logic [62:0] sum;
   logic [16:0] rnd;
   logic [15:0] refl_in;
   always_comb begin
      sum = 63'(sqs_ff) + 63'(sqp_ff) + (63'd1 << 45);
      rnd = sum[62:46];
      if (tir_sq_ff || rnd > 17'(fr_pkg::ONE_Q15)) begin
         refl_in = fr_pkg::ONE_Q15;
      end else begin
         refl_in = rnd[15:0];
      end
   end

   logic [15:0] refl_ff;
   logic        tir_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         refl_ff <= refl_in;
         tir_ff  <= tir_sq_ff;
      end
   end

   assign rsp_ch.reflectance    = refl_ff;
   assign rsp_ch.total_internal = tir_ff;

endmodule

/* src/fr_checker.sv */
module fr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] reflectance,
   input logic        total_internal
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> reflectance <= 16'd32768)
      else $error("reflectance above 1.0");

   a_tir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && total_internal |-> reflectance == 16'd32768)
      else $error("total reflection without full reflectance");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind fresnel_reflectance fr_checker u_fr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .reflectance    (rsp_ch.reflectance),
   .total_internal (rsp_ch.total_internal)
);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

   typedef struct {
      logic [14:0]        index;
      logic signed [15:0] dx, dy, dz, nx, ny, nz;
      bit                 known;
      logic [15:0]        refl;
      logic               tir;
   } stim_row_type;

   typedef struct {
      logic [15:0] refl;
      logic        tir;
   } refl_type;

   localparam longint unsigned ONE_Q28 = 64'd1 << 28;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fr_req_if req_ch ();
   fr_rsp_if rsp_ch ();

   fresnel_reflectance u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   logic [14:0] cur_index;
   refl_type    pending_refl[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_checked = 0;
   int          n_tir = 0;
   bit          no_idle = 1'b0;

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.dir_x  = '0;
      req_ch.dir_y  = '0;
      req_ch.dir_z  = '0;
      req_ch.norm_x = '0;
      req_ch.norm_y = '0;
      req_ch.norm_z = '0;
      rsp_ch.ready  = 1'b0;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned half_ratio(longint unsigned a, longint unsigned b);
      longint unsigned num;
      longint unsigned den;
      num = (a >= b) ? a - b : b - a;
      den = a + b;
      if (den == 0) return 64'd1 << 30;
      return (num << 30) / den;
   endfunction

   function automatic refl_type fresnel(logic [14:0] index, logic signed [15:0] dx,
                                        logic signed [15:0] dy, logic signed [15:0] dz,
                                        logic signed [15:0] nx, logic signed [15:0] ny,
                                        logic signed [15:0] nz);
      longint          dot;
      longint unsigned eta_i, eta_t, ci, sin_i, sin_t, cos_t, rs, rp, sum, r;
      refl_type        o;
      dot = longint'(dx) * nx + longint'(dy) * ny + longint'(dz) * nz;
      if (dot > longint'(ONE_Q28)) dot = ONE_Q28;
      if (dot < -longint'(ONE_Q28)) dot = -longint'(ONE_Q28);
      // leaving the material: swap the indices
      if (dot > 0) begin
         eta_i = index;
         eta_t = fr_pkg::ETA_ONE;
      end else begin
         eta_i = fr_pkg::ETA_ONE;
         eta_t = index;
      end
      ci    = (dot < 0) ? -dot : dot;
      sin_i = floor_sqrt((ONE_Q28 << 28) - ci * ci);
      o.refl = fr_pkg::ONE_Q15;
      o.tir  = 1'b1;
      if (eta_t == 0) return o;
      sin_t = (eta_i * sin_i) / eta_t;
      if (sin_t >= ONE_Q28) return o;
      cos_t = floor_sqrt((ONE_Q28 << 28) - sin_t * sin_t);
      rs  = half_ratio((eta_t * ci) >> 12, (eta_i * cos_t) >> 12);
      rp  = half_ratio((eta_i * ci) >> 12, (eta_t * cos_t) >> 12);
      sum = rs * rs + rp * rp;
      r   = (sum + (64'd1 << 45)) >> 46;
      if (r > fr_pkg::ONE_Q15) r = fr_pkg::ONE_Q15;
      o.refl = r[15:0];
      o.tir  = 1'b0;
      return o;
   endfunction

   function automatic stim_row_type make_row(int index, int dx, int dy, int dz,
                                             int nx, int ny, int nz, bit known,
                                             int refl, bit tir);
      stim_row_type s;
      s.index = 15'(index);
      s.dx    = 16'(dx);
      s.dy    = 16'(dy);
      s.dz    = 16'(dz);
      s.nx    = 16'(nx);
      s.ny    = 16'(ny);
      s.nz    = 16'(nz);
      s.known = known;
      s.refl  = 16'(refl);
      s.tir   = tir;
      return s;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %0d want %0d", n_checked, what, got, want);
   endtask

   task automatic write_index(logic [14:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(fr_pkg::CSR_IDX_INDEX * 4);
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_index = value;
   endtask

   task automatic drain();
      while (pending_refl.size() != 0) @(posedge clock);
   endtask

   // expected results are pushed at the edge where the transfer happens
   task automatic send_ray(logic signed [15:0] dx, logic signed [15:0] dy,
                           logic signed [15:0] dz, logic signed [15:0] nx,
                           logic signed [15:0] ny, logic signed [15:0] nz,
                           bit known, refl_type want);
      int  gap;
      bit  rdy;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.dir_x  <= dx;
      req_ch.dir_y  <= dy;
      req_ch.dir_z  <= dz;
      req_ch.norm_x <= nx;
      req_ch.norm_y <= ny;
      req_ch.norm_z <= nz;
      do begin
         @(negedge clock);
         rdy = req_ch.ready;
         @(posedge clock);
      end while (!rdy);
      if (!known) want = fresnel(cur_index, dx, dy, dz, nx, ny, nz);
      pending_refl.push_back(want);
      n_sent++;
   endtask

   initial begin : result_side
      int       stall;
      bit       hit;
      refl_type want;
      @(posedge clock iff !reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do begin
            @(negedge clock);
            hit = rsp_ch.valid && rsp_ch.ready;
            @(posedge clock);
         end while (!hit);
         if (pending_refl.size() == 0) begin
            errors++;
            $display("unexpected result transfer, reflectance %0d", rsp_ch.reflectance);
         end else begin
            want = pending_refl.pop_front();
            if (rsp_ch.reflectance !== want.refl)
               report("reflectance", 32'(rsp_ch.reflectance), 32'(want.refl));
            if (rsp_ch.total_internal !== want.tir)
               report("total_internal", 32'(rsp_ch.total_internal), 32'(want.tir));
            if (want.tir) n_tir++;
         end
         n_checked++;
      end
   end

   function automatic logic signed [15:0] rnd_comp(bit wide);
      return wide ? 16'($urandom) : 16'($signed($urandom_range(0, 36000)) - 18000);
   endfunction

   initial begin : stimulus
      stim_row_type    rows[$];
      refl_type        want;
      logic [14:0]     phases[$];
      bit              wide;
      int              ir;
      int              one;
      cur_index = fr_pkg::INDEX_RESET;
      ir  = int'(fr_pkg::INDEX_RESET);
      one = int'(fr_pkg::ONE_Q15);
      rows.push_back(make_row(ir, 1, 0, 0, 1, 0, 0, 1'b1, one, 1'b1));
      rows.push_back(make_row(ir, 0, 0, -16384, 0, 0, 16384, 1'b0, 0, 1'b0));
      rows.push_back(make_row(ir, 16384, 0, 0, 0, 16384, 0, 1'b0, 0, 1'b0));
      rows.push_back(make_row(ir, 16384, 0, 0, 16384, 0, 0, 1'b0, 0, 1'b0));
      rows.push_back(make_row(ir, -32768, -32768, -32768,
                              -32768, -32768, -32768, 1'b0, 0, 1'b0));
      rows.push_back(make_row(ir, 32767, 32767, 32767,
                              -32768, -32768, -32768, 1'b0, 0, 1'b0));
      rows.push_back(make_row(ir, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0));
      rows.push_back(make_row(ir, 11585, 0, -11585, 0, 0, 16384, 1'b0, 0, 1'b0));
      rows.push_back(make_row(ir, 11585, 0, 11585, 0, 0, 16384, 1'b0, 0, 1'b0));
      rows.push_back(make_row(0, 0, 0, -16384, 0, 0, 16384, 1'b1, one, 1'b1));
      rows.push_back(make_row(0, 0, 0, 16384, 0, 0, 16384, 1'b0, 0, 1'b0));
      rows.push_back(make_row(0, 16384, 0, 0, 0, 16384, 0, 1'b1, one, 1'b1));
      rows.push_back(make_row(32767, 1, 0, 0, 1, 0, 0, 1'b1, one, 1'b1));
      rows.push_back(make_row(32767, 0, 0, -16384, 0, 0, 16384, 1'b0, 0, 1'b0));
      rows.push_back(make_row(32767, 16384, 0, 0, 0, 16384, 0, 1'b0, 0, 1'b0));
      rows.push_back(make_row(1024, 16384, 0, 0, 0, 16384, 0, 1'b0, 0, 1'b0));
      rows.push_back(make_row(1024, 1, 0, 0, 1, 0, 0, 1'b0, 0, 1'b0));
      rows.push_back(make_row(1024, 0, -9000, -13000, 0, 0, 16384, 1'b0, 0, 1'b0));
      rows.push_back(make_row(int'(fr_pkg::ETA_ONE), 3000, -9000, 12000, 0, 0, 16384,
                              1'b0, 0, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].index != cur_index) begin
            req_ch.valid <= 1'b0;
            drain();
            write_index(rows[i].index);
         end
         want.refl = rows[i].refl;
         want.tir  = rows[i].tir;
         send_ray(rows[i].dx, rows[i].dy, rows[i].dz, rows[i].nx, rows[i].ny,
                  rows[i].nz, rows[i].known, want);
      end

      phases = '{15'd1024, 15'd32767, fr_pkg::INDEX_RESET, fr_pkg::ETA_ONE, 15'd8192,
                 15'd5461, 15'($urandom_range(1024, 32767)),
                 15'($urandom_range(1024, 8192))};
      foreach (phases[p]) begin
         req_ch.valid <= 1'b0;
         drain();
         write_index(phases[p]);
         no_idle = (p % 3 == 2);
         repeat (235) begin
            wide = ($urandom_range(0, 3) == 0);
            send_ray(rnd_comp(wide), rnd_comp(wide), rnd_comp(wide),
                     rnd_comp(wide), rnd_comp(wide), rnd_comp(wide), 0, want);
         end
      end
      req_ch.valid <= 1'b0;
      drain();
      repeat (140) @(posedge clock);

      $display("sent %0d rays over %0d index settings, checked %0d results (%0d total internal)",
               n_sent, phases.size() + 5, n_checked, n_tir);
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("timeout waiting for results");
      $display("tb failed");
      $finish;
   end

endmodule
